[src/hcbd_pkg.sv]
// types and constants shared by the chunked body decoder modules
// no dependencies
package hcbd_pkg;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END = 2'd1;
	localparam logic [1:0] KIND_OVERFLOW = 2'd2;

	typedef enum logic [1:0] {
		PH_SIZE = 2'd0,
		PH_DATA = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic new_body;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] payload_byte;
	} out_item_t;

	// byte after classification, as the back end consumes it
	typedef struct packed {
		logic [7:0] data;
		logic new_body;
		logic is_cr;
		logic is_lf;
		logic is_hex;
		logic [3:0] hex_val;
	} class_word_t;

	function automatic class_word_t classify(input in_item_t it);
		class_word_t w;
		logic [7:0] c;
		c = it.in_byte;
		w.data = c;
		w.new_body = it.new_body;
		w.is_cr = (c == CHAR_CR);
		w.is_lf = (c == CHAR_LF);
		w.is_hex = 1'b1;
		w.hex_val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			w.hex_val = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			w.hex_val = c[3:0] + 4'd9;
		end else begin
			w.is_hex = 1'b0;
		end
		return w;
	endfunction

endpackage

[src/hcbd_front.sv]
// front end: takes input words and registers their classification
// depends on hcbd_pkg
module hcbd_front (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input hcbd_pkg::in_item_t item,
	output logic item_stall,
	output logic push,
	output hcbd_pkg::class_word_t push_word,
	input logic queue_full
);
	import hcbd_pkg::*;

	logic valid_s1;
	class_word_t word_s1;

	assign push = valid_s1 && !queue_full;
	assign item_stall = valid_s1 && queue_full;
	assign push_word = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			word_s1 <= classify(item);
		end
	end

endmodule

[src/hcbd_queue.sv]
// short queue of classified words between front and back ends
// depends on hcbd_pkg
module hcbd_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input hcbd_pkg::class_word_t push_word,
	output logic full,
	input logic pop,
	output logic not_empty,
	output hcbd_pkg::class_word_t head
);
	import hcbd_pkg::*;

	class_word_t slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0] count_q;

	assign full = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

[src/hcbd_back.sv]
// back end: size line parser, chunk byte counter and result register
// depends on hcbd_pkg
module hcbd_back #(
	parameter int SIZE_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic word_valid,
	input hcbd_pkg::class_word_t word,
	output logic pop,
	output logic result_valid,
	output hcbd_pkg::out_item_t result,
	input logic result_stall
);
	import hcbd_pkg::*;

	phase_t phase_q, phase_d;
	logic [SIZE_BITS-1:0] accum_q, accum_d;
	logic [SIZE_BITS-1:0] left_q, left_d;
	logic digits_ended_q, digits_ended_d;
	logic cr_pending_q, cr_pending_d;
	logic line_empty_q, line_empty_d;
	logic skip_allowed_q, skip_allowed_d;

	phase_t ph;
	logic [SIZE_BITS-1:0] acc, lft, dec;
	logic de, crp, le, skp;
	logic res_valid;
	out_item_t res;
	logic out_free;

	always_comb begin
		// new body clears state ahead of this byte
		if (word.new_body) begin
			ph = PH_SIZE;
			acc = '0;
			lft = '0;
			de = 1'b0;
			crp = 1'b0;
			le = 1'b1;
			skp = 1'b0;
		end else begin
			ph = phase_q;
			acc = accum_q;
			lft = left_q;
			de = digits_ended_q;
			crp = cr_pending_q;
			le = line_empty_q;
			skp = skip_allowed_q;
		end
		dec = lft - 1'b1;

		phase_d = ph;
		accum_d = acc;
		left_d = lft;
		digits_ended_d = de;
		cr_pending_d = crp;
		line_empty_d = le;
		skip_allowed_d = skp;
		res_valid = 1'b0;
		res.kind = KIND_DATA;
		res.payload_byte = 8'd0;

		unique case (ph)
			PH_DATA: begin
				left_d = dec;
				res_valid = 1'b1;
				res.payload_byte = word.data;
				if (dec == '0) begin
					phase_d = PH_SIZE;
					accum_d = '0;
					digits_ended_d = 1'b0;
					cr_pending_d = 1'b0;
					line_empty_d = 1'b1;
					skip_allowed_d = 1'b1;
				end
			end
			PH_SIZE: begin
				if (word.is_cr) begin
					cr_pending_d = 1'b1;
					if (!(le && skp && !crp)) begin
						digits_ended_d = 1'b1;
						line_empty_d = 1'b0;
					end
				end else if (word.is_lf && crp) begin
					if (le && skp) begin
						// leading cr lf after chunk data is skipped
						accum_d = '0;
						digits_ended_d = 1'b0;
						cr_pending_d = 1'b0;
						line_empty_d = 1'b1;
						skip_allowed_d = 1'b0;
					end else if (acc == '0) begin
						phase_d = PH_DONE;
						res_valid = 1'b1;
						res.kind = KIND_END;
					end else begin
						left_d = acc;
						phase_d = PH_DATA;
					end
				end else begin
					line_empty_d = 1'b0;
					skip_allowed_d = 1'b0;
					cr_pending_d = 1'b0;
					if (crp || de || !word.is_hex) begin
						digits_ended_d = 1'b1;
					end else if (acc[SIZE_BITS-1 -: 4] != 4'd0) begin
						phase_d = PH_DONE;
						res_valid = 1'b1;
						res.kind = KIND_OVERFLOW;
					end else begin
						accum_d = {acc[SIZE_BITS-5:0], word.hex_val};
					end
				end
			end
			default: begin
				// ended: bytes dropped until a new body
			end
		endcase
	end

	assign out_free = !result_valid || !result_stall;
	assign pop = word_valid && (!res_valid || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE;
			accum_q <= '0;
			left_q <= '0;
			digits_ended_q <= 1'b0;
			cr_pending_q <= 1'b0;
			line_empty_q <= 1'b1;
			skip_allowed_q <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_d;
				accum_q <= accum_d;
				left_q <= left_d;
				digits_ended_q <= digits_ended_d;
				cr_pending_q <= cr_pending_d;
				line_empty_q <= line_empty_d;
				skip_allowed_q <= skip_allowed_d;
			end
			if (pop && res_valid) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			result <= res;
		end
	end

endmodule

[src/http_chunked_body_decoder_core.sv]
// Decodes an HTTP chunked body, one byte per cycle while nothing stalls. A byte
// passes a classification register and a four-word queue, then the size line
// parser and chunk counter update on each byte taken from the queue; results
// (payload bytes, end of body, size overflow) leave through an output register.
// Bytes that give no result keep flowing while a result waits.
// Depends on hcbd_pkg, hcbd_front, hcbd_queue and hcbd_back.
module http_chunked_body_decoder_core #(
	parameter int SIZE_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input hcbd_pkg::in_item_t item,
	output logic item_stall,
	output logic result_valid,
	output hcbd_pkg::out_item_t result,
	input logic result_stall
);
	import hcbd_pkg::*;

	logic push, queue_full, pop, not_empty;
	class_word_t push_word, head;

	hcbd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item(item),
		.item_stall(item_stall),
		.push(push),
		.push_word(push_word),
		.queue_full(queue_full)
	);

	hcbd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_word(push_word),
		.full(queue_full),
		.pop(pop),
		.not_empty(not_empty),
		.head(head)
	);

	hcbd_back #(
		.SIZE_BITS(SIZE_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.word_valid(not_empty),
		.word(head),
		.pop(pop),
		.result_valid(result_valid),
		.result(result),
		.result_stall(result_stall)
	);

endmodule

[test/tb_http_chunked_body_decoder_core.sv]
// self-checking testbench for http_chunked_body_decoder_core: chunked bodies, broken
// lines and noise go in byte by byte, and each result word is checked against a predictor
// depends on hcbd_pkg and the decoder rtl
module tb_http_chunked_body_decoder_core;
	timeunit 1ns;
	timeprecision 1ps;
	import hcbd_pkg::*;

	localparam int SIZE_BITS = 32;
	localparam int RANDOM_WORDS = 850;
	localparam int TAIL_WORDS = 120;

	typedef struct packed {
		in_item_t word;
		logic drain_first;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	in_item_t item = '0;
	logic item_stall;
	logic result_valid;
	out_item_t result;
	logic result_stall = 1'b0;

	stim_t pending_words[$];
	out_item_t expected_results[$];
	bit fresh_body = 1'b0;
	bit hold_next = 1'b0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	bit send_bursty = 1'b1;
	bit recv_bursty = 1'b1;
	int unsigned fail_count = 0;
	int unsigned words_sent = 0;
	int unsigned payload_seen = 0;
	int unsigned ends_seen = 0;
	int unsigned overflows_seen = 0;

	// mirrored decoder state
	phase_t dec_phase;
	logic [SIZE_BITS-1:0] dec_size;
	logic [SIZE_BITS-1:0] dec_left;
	logic dec_junk;
	logic dec_cr;
	logic dec_empty;
	logic dec_skip;

	http_chunked_body_decoder_core #(
		.SIZE_BITS(SIZE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item(item),
		.item_stall(item_stall),
		.result_valid(result_valid),
		.result(result),
		.result_stall(result_stall)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void start_line(input logic may_skip);
		dec_size = '0;
		dec_junk = 1'b0;
		dec_cr = 1'b0;
		dec_empty = 1'b1;
		dec_skip = may_skip;
	endfunction

	function automatic void clear_decoder();
		dec_phase = PH_SIZE;
		dec_left = '0;
		start_line(1'b0);
	endfunction

	function automatic void expect_result(input logic [1:0] k, input logic [7:0] b);
		out_item_t r;
		r.kind = k;
		r.payload_byte = b;
		expected_results = {expected_results, r};
	endfunction

	function automatic int hex_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
		if (c >= 8'h61 && c <= 8'h66) return c - 8'h57;
		if (c >= 8'h41 && c <= 8'h46) return c - 8'h37;
		return -1;
	endfunction

	function automatic void decode_word(input in_item_t w);
		int digit;
		logic [7:0] c;
		c = w.in_byte;
		if (w.new_body) clear_decoder();
		if (dec_phase == PH_DATA) begin
			dec_left = dec_left - 1'b1;
			if (dec_left == '0) begin
				dec_phase = PH_SIZE;
				start_line(1'b1);
			end
			expect_result(KIND_DATA, c);
			return;
		end
		if (dec_phase != PH_SIZE) return;
		if (c == CHAR_CR) begin
			// a first CR right after chunk data may open the skipped CR LF
			if (!(dec_empty && dec_skip && !dec_cr)) begin
				dec_junk = 1'b1;
				dec_empty = 1'b0;
			end
			dec_cr = 1'b1;
			return;
		end
		if (c == CHAR_LF && dec_cr) begin
			if (dec_empty && dec_skip) begin
				start_line(1'b0);
			end else if (dec_size == '0) begin
				dec_phase = PH_DONE;
				expect_result(KIND_END, 8'h00);
			end else begin
				dec_left = dec_size;
				dec_phase = PH_DATA;
			end
			return;
		end
		if (dec_cr) begin
			dec_junk = 1'b1;
			dec_cr = 1'b0;
		end
		dec_empty = 1'b0;
		dec_skip = 1'b0;
		digit = hex_of(c);
		if (dec_junk || digit < 0) begin
			dec_junk = 1'b1;
		end else if (dec_size[SIZE_BITS-1 -: 4] != 4'd0) begin
			dec_phase = PH_DONE;
			expect_result(KIND_OVERFLOW, 8'h00);
		end else begin
			dec_size = {dec_size[SIZE_BITS-5:0], digit[3:0]};
		end
	endfunction

	function automatic void add_word(input logic [7:0] b);
		stim_t s;
		s.word.in_byte = b;
		s.word.new_body = fresh_body;
		s.drain_first = hold_next;
		fresh_body = 1'b0;
		hold_next = 1'b0;
		pending_words = {pending_words, s};
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) add_word(s[i]);
	endfunction

	function automatic void add_crlf();
		add_word(CHAR_CR);
		add_word(CHAR_LF);
	endfunction

	function automatic logic [7:0] pick_hex(input bit nonzero);
		string digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(nonzero ? 1 : 0, 21)];
	endfunction

	function automatic void add_size_line(input int unsigned sz);
		string txt;
		txt = $sformatf("%0h", sz);
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) txt = {"0", txt};
		for (int i = 0; i < txt.len(); i++) begin
			if (txt[i] >= "a" && $urandom_range(0, 1) == 1) txt[i] = txt[i] - 8'h20;
		end
		add_text(txt);
		// chunk extension, sometimes with a stray CR inside
		if ($urandom_range(0, 3) == 0) begin
			add_word(";");
			repeat ($urandom_range(0, 6)) add_word(8'($urandom_range(8'h20, 8'h7e)));
			if ($urandom_range(0, 2) == 0) begin
				add_word(CHAR_CR);
				add_word("x");
			end
		end
		add_crlf();
	endfunction

	function automatic void add_body();
		int unsigned chunks;
		int unsigned sz;
		int unsigned ending;
		chunks = $urandom_range(0, 4);
		ending = $urandom_range(0, 19);
		fresh_body = 1'b1;
		for (int k = 0; k < chunks; k++) begin
			sz = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			add_size_line(sz);
			repeat (sz) add_word(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 9) != 0) add_crlf();
		end
		if (ending < 14) begin
			add_text("0");
			add_crlf();
		end else if (ending < 16) begin
			add_crlf();
		end else if (ending < 18) begin
			add_word(pick_hex(1'b1));
			repeat ($urandom_range(8, 9)) add_word(pick_hex(1'b0));
		end else if (ending == 18) begin
			// cut short, the next body starts in the middle
			return;
		end else begin
			repeat ($urandom_range(1, 12)) add_word(8'($urandom_range(0, 255)));
		end
		repeat ($urandom_range(0, 3)) add_word(8'($urandom_range(0, 255)));
	endfunction

	always @(posedge clk) begin : driver
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				decode_word(item);
				words_sent++;
			end
			if (!(item_valid && item_stall)) begin
				if (gap_left != 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (pending_words.size() != 0 &&
						!(pending_words[0].drain_first && expected_results.size() != 0)) begin
					item <= pending_words[0].word;
					item_valid <= 1'b1;
					void'(pending_words.pop_front());
					if (pending_words.size() >= TAIL_WORDS && send_bursty &&
							$urandom_range(0, 3) == 0)
						gap_left = $urandom_range(1, 14);
					if ($urandom_range(0, 49) == 0) send_bursty = !send_bursty;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		out_item_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result word: kind %0d, payload_byte %02h",
						result.kind, result.payload_byte);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (result.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, result.kind);
						fail_count++;
					end
					if (result.payload_byte !== want.payload_byte) begin
						$error("payload_byte: expected %02h, got %02h",
							want.payload_byte, result.payload_byte);
						fail_count++;
					end
					case (want.kind)
						KIND_DATA: payload_seen++;
						KIND_END: ends_seen++;
						default: overflows_seen++;
					endcase
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (pending_words.size() >= TAIL_WORDS && recv_bursty &&
					$urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 13);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
			if ($urandom_range(0, 99) == 0) recv_bursty = !recv_bursty;
		end
	end

	initial begin : stimulus
		int unsigned directed;
		clear_decoder();

		// a CR LF at the very start of a body is an empty size line
		fresh_body = 1'b1;
		add_crlf();
		// stray CR ends the digits, skipped CR LF after data, bytes dropped after the end
		fresh_body = 1'b1;
		add_text("1");
		add_word(CHAR_CR);
		add_text("x");
		add_crlf();
		add_word(8'hFF);
		add_crlf();
		add_text("0");
		add_crlf();
		add_word(8'h00);
		// nine digits overflow a 32 bit size
		fresh_body = 1'b1;
		add_text("A1b2C3d4e");

		directed = pending_words.size();
		hold_next = 1'b1;
		while (pending_words.size() < directed + RANDOM_WORDS) begin
			if (pending_words.size() >= directed + RANDOM_WORDS / 2 &&
					pending_words.size() < directed + RANDOM_WORDS / 2 + 4)
				hold_next = 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 10)) begin
					fresh_body = ($urandom_range(0, 7) == 0);
					add_word(8'($urandom_range(0, 255)));
				end
			end else begin
				add_body();
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || item_valid) @(posedge clk);
		for (int i = 0; i < 2000 && expected_results.size() != 0; i++) @(posedge clk);
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected result words never arrived", expected_results.size());
			fail_count++;
		end

		$display("sent %0d bytes; checked %0d payload bytes, %0d body ends, %0d size overflows",
			words_sent, payload_seen, ends_seen, overflows_seen);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin : watchdog
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

[sim.f]
src/hcbd_pkg.sv
src/hcbd_front.sv
src/hcbd_queue.sv
src/hcbd_back.sv
src/http_chunked_body_decoder_core.sv
test/tb_http_chunked_body_decoder_core.sv
